// ===== rtl/accel_tilt_angles_assert.svh =====
// Assertion macros for the tilt-angle block.
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ATA_ASSERT(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ATA_ASSERT_NEXT(lbl, ante, cons, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ATA_ASSERT(lbl, prop, clk, rst_n)
`define ATA_ASSERT_NEXT(lbl, ante, cons, clk, rst_n)
`endif
`endif

// ===== rtl/ata_pkg.sv =====
package ata_pkg;

  localparam int unsigned AngleFracBits = 7;
  localparam int unsigned CordicSteps   = 16;
  localparam int unsigned AccFrac       = 24;
  localparam int unsigned TabLen        = 24;
  // Output field widths: +-90 deg and +-180 deg with AngleFracBits fraction bits.
  localparam int unsigned PitchW        = 8 + AngleFracBits;
  localparam int unsigned RollW         = 9 + AngleFracBits;
  // Datapath width for CORDIC x/y (values stay below 2^33 in magnitude).
  localparam int unsigned DW            = 36;
  // Angle accumulator width (degrees * 2^24, within +-270 deg).
  localparam int unsigned AW            = 34;

  localparam logic signed [AW-1:0] Deg90  = AW'(64'sd90 <<< AccFrac);
  localparam logic signed [AW-1:0] Deg180 = AW'(64'sd180 <<< AccFrac);

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [PitchW-1:0] pitch_angle;
    logic signed [RollW-1:0]  roll_angle;
  } out_item_t;

  // atan(2^-i) in degrees * 2^24
  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0: v = 34'sd754974720;   5'd1: v = 34'sd445687602;
      5'd2: v = 34'sd235489089;   5'd3: v = 34'sd119537938;
      5'd4: v = 34'sd60000934;    5'd5: v = 34'sd30029717;
      5'd6: v = 34'sd15018523;    5'd7: v = 34'sd7509720;
      5'd8: v = 34'sd3754917;     5'd9: v = 34'sd1877466;
      5'd10: v = 34'sd938734;     5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;     5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;       5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;        5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;        5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ata_sqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage.
// Input 64-bit value (only up to 2^63), output 32-bit root.
module ata_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  localparam int unsigned NS = 32;

  logic [63:0] rem_q  [NS];
  logic [31:0] root_q [NS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        logic [63:0] rin;
        logic [31:0] qin;
        logic [33:0] trial;
        logic [33:0] part;
        rin = (s == 0) ? rad_i : rem_q[s-1];
        qin = (s == 0) ? '0 : root_q[s-1];
        // partial remainder window aligned for bit (31-s)
        part  = 34'(rin >> (2 * (31 - s)));
        trial = {qin, 2'b01};
        if (part >= trial) begin
          rem_q[s]  <= rin - (64'(trial) << (2 * (31 - s)));
          root_q[s] <= {qin[30:0], 1'b1};
        end else begin
          rem_q[s]  <= rin;
          root_q[s] <= {qin[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[NS-1];
endmodule

// ===== rtl/ata_cordic.sv =====
// Pipelined vectoring CORDIC: quadrant fold, then one micro-rotation per stage.
module ata_cordic #(
  parameter int unsigned CORDIC_STEPS = ata_pkg::CordicSteps
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [ata_pkg::DW-1:0] cx_i,
  input  logic signed [ata_pkg::DW-1:0] sy_i,
  input  logic                          force_i,
  input  logic signed [ata_pkg::AW-1:0] force_val_i,
  output logic signed [ata_pkg::AW-1:0] acc_o
);
  localparam int unsigned NS = (CORDIC_STEPS > ata_pkg::TabLen) ?
                               ata_pkg::TabLen : CORDIC_STEPS;
  localparam int unsigned DW = ata_pkg::DW;
  localparam int unsigned AW = ata_pkg::AW;

  logic signed [DW-1:0] x_q   [NS+1];
  logic signed [DW-1:0] y_q   [NS+1];
  logic signed [AW-1:0] acc_q [NS+1];
  logic                 fix_q [NS+1];

  // Stage 0: special cases and quadrant fold.
  always_ff @(posedge clk_i) begin
    logic signed [DW-1:0] x0, y0;
    logic signed [AW-1:0] a0;
    logic                 f0;
    x0 = cx_i;
    y0 = sy_i;
    a0 = '0;
    f0 = 1'b0;
    if (force_i) begin
      a0 = force_val_i;
      f0 = 1'b1;
    end else if (cx_i == '0) begin
      f0 = 1'b1;
      a0 = (sy_i > 0) ? ata_pkg::Deg90 :
           ((sy_i < 0) ? -ata_pkg::Deg90 : '0);
    end else if (cx_i < 0) begin
      if (sy_i == '0) begin
        f0 = 1'b1;
        a0 = ata_pkg::Deg180;
      end else if (sy_i > 0) begin
        x0 = sy_i;  y0 = -cx_i; a0 = ata_pkg::Deg90;
      end else begin
        x0 = -sy_i; y0 = cx_i;  a0 = -ata_pkg::Deg90;
      end
    end
    if (en_i) begin
      x_q[0]   <= x0;
      y_q[0]   <= y0;
      acc_q[0] <= a0;
      fix_q[0] <= f0;
    end
  end

  // Micro-rotation stages.
  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fix_q[i+1] <= fix_q[i];
        if (fix_q[i]) begin
          x_q[i+1]   <= x_q[i];
          y_q[i+1]   <= y_q[i];
          acc_q[i+1] <= acc_q[i];
        end else if (y_q[i] >= 0) begin
          x_q[i+1]   <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1]   <= y_q[i] - (x_q[i] >>> i);
          acc_q[i+1] <= acc_q[i] + ata_pkg::atan_tab(5'(i));
        end else begin
          x_q[i+1]   <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1]   <= y_q[i] + (x_q[i] >>> i);
          acc_q[i+1] <= acc_q[i] - ata_pkg::atan_tab(5'(i));
        end
      end
    end
  end

  assign acc_o = acc_q[NS];
endmodule

// ===== rtl/accel_tilt_angles.sv =====
// Pipeline: 32 square-root stages, one fold stage, one rotation stage per CORDIC step
//   (at most 24), and one rounding/output stage.
// Throughput: one item per cycle; the whole pipeline advances when the output
//   register is empty or being taken, so a stall freezes every stage.
// Reset: rst_ni asynchronously clears the valid bits only; data is not reset.
module accel_tilt_angles #(
  parameter int unsigned CORDIC_STEPS    = ata_pkg::CordicSteps
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ata_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ata_pkg::out_item_t   out_data_o
);
  `include "accel_tilt_angles_assert.svh"

  localparam int unsigned DW  = ata_pkg::DW;
  localparam int unsigned AW  = ata_pkg::AW;
  localparam int unsigned NC  = (CORDIC_STEPS > ata_pkg::TabLen) ?
                                ata_pkg::TabLen : CORDIC_STEPS;
  localparam int unsigned LAT = 32 + 1 + NC;
  localparam int unsigned SH  = ata_pkg::AccFrac - ata_pkg::AngleFracBits;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Valid shift line, one bit per datapath stage.
  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Sum of squares, then the root of (x^2+z^2)<<30.
  logic [31:0] sq_x, sq_z;
  logic [32:0] sq;
  logic [31:0] root;
  assign sq_x = 32'(32'(in_data_i.accel_x) * 32'(in_data_i.accel_x));
  assign sq_z = 32'(32'(in_data_i.accel_z) * 32'(in_data_i.accel_z));
  assign sq   = 33'(sq_x) + 33'(sq_z);

  ata_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i ({1'b0, sq, 30'b0}),
    .root_o(root)
  );

  // Delay inputs alongside the square root.
  ata_pkg::in_item_t dly_q [32];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= in_data_i;
      for (int k = 1; k < 32; k++) dly_q[k] <= dly_q[k-1];
    end
  end

  ata_pkg::in_item_t d;
  logic signed [DW-1:0] ps_y, ps_x, rs_y, rs_x;
  logic rforce;
  assign d     = dly_q[31];
  assign ps_x  = DW'($signed({1'b0, root}));
  assign ps_y  = DW'($signed(d.accel_y)) <<< 15;
  assign rs_x  = DW'($signed(d.accel_z)) <<< 15;
  assign rs_y  = -(DW'($signed(d.accel_x)) <<< 15);
  assign rforce = (d.accel_x == '0) && d.accel_z[15];

  logic signed [AW-1:0] pacc, racc;

  ata_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i(clk_i), .en_i(en), .cx_i(ps_x), .sy_i(ps_y),
    .force_i(1'b0), .force_val_i('0), .acc_o(pacc)
  );
  ata_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk_i(clk_i), .en_i(en), .cx_i(rs_x), .sy_i(rs_y),
    .force_i(rforce), .force_val_i(-ata_pkg::Deg180), .acc_o(racc)
  );

  // Clamp and round to nearest, halves up.
  function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] a,
                                               input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] c;
    c = (a > lim) ? lim : ((a < -lim) ? -lim : a);
    return (c + (AW'(1) <<< (SH - 1))) >>> SH;
  endfunction

  logic signed [AW-1:0] p_r, r_r;
  assign p_r = rnd(pacc, ata_pkg::Deg90);
  assign r_r = rnd(racc, ata_pkg::Deg180);

  logic out_v_q;
  ata_pkg::out_item_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vld_q[LAT-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.pitch_angle <= p_r[ata_pkg::PitchW-1:0];
      out_q.roll_angle  <= r_r[ata_pkg::RollW-1:0];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `ATA_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, clk_i, rst_ni)
  `ATA_ASSERT_NEXT(a_hold_on_stall, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), clk_i, rst_ni)
  `ATA_ASSERT_NEXT(a_freeze_valids, !en, $stable(vld_q), clk_i, rst_ni)
endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 7;
  localparam int Steps    = 16;
  localparam int Latency  = 50;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  ata_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  ata_pkg::out_item_t out_data_o;

  accel_tilt_angles dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  ata_pkg::in_item_t  samples_q[$];
  ata_pkg::out_item_t angles_q[$];
  int        errors = 0;
  bit        hold_tx = 1'b0;
  bit        hold_rx = 1'b0;

  // angle table, atan(2^-i) in degrees * 2^24
  longint atan_lut[24] = '{754974720, 445687602, 235489089, 119537938, 60000934,
    30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring rotation, angle in degrees * 2^24
  function automatic longint vector_angle(longint sy, longint cx);
    longint acc, x, y, t;
    int n;
    acc = 0; x = cx; y = sy;
    n = (Steps > 24) ? 24 : Steps;
    if (cx == 0) return (sy > 0) ? (64'sd90 <<< 24) : ((sy < 0) ? -(64'sd90 <<< 24) : 0);
    if (cx < 0) begin
      if (sy == 0) return 64'sd180 <<< 24;
      if (sy > 0) begin
        x = sy; y = -cx; acc = 64'sd90 <<< 24;
      end else begin
        x = -sy; y = cx; acc = -(64'sd90 <<< 24);
      end
    end
    for (int i = 0; i < n; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + floor_shift(y, i); y = y - floor_shift(t, i); acc += atan_lut[i];
      end else begin
        x = x - floor_shift(y, i); y = y + floor_shift(t, i); acc -= atan_lut[i];
      end
    end
    return acc;
  endfunction

  function automatic longint round_angle(longint acc, longint lim);
    int s;
    s = 24 - FracBits;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    return floor_shift(acc + (64'sd1 <<< (s - 1)), s);
  endfunction

  function automatic ata_pkg::out_item_t tilt_angles(ata_pkg::in_item_t s);
    longint ax, ay, az, r, pacc, racc;
    longint unsigned sq;
    ata_pkg::out_item_t o;
    ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
    sq = longint'(ax * ax) + longint'(az * az);
    r = int_sqrt(sq << 30);
    pacc = vector_angle(ay * 32768, r);
    if (ax == 0 && az < 0) racc = -(64'sd180 <<< 24);
    else racc = vector_angle(-ax * 32768, az * 32768);
    o.pitch_angle = 15'(round_angle(pacc, 64'sd90 <<< 24));
    o.roll_angle  = 16'(round_angle(racc, 64'sd180 <<< 24));
    return o;
  endfunction

  function automatic logic [15:0] rnd_axis();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // driver: bursts and gaps, payload held until accepted
  int gap_left = 0, burst_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) void'(samples_q.pop_front());
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (!hold_tx && samples_q.size() > 0 && gap_left == 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= samples_q[0];
        burst_left = burst_left - 1;
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end
    end
  end

  // expectations are formed at acceptance
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) angles_q.push_back(tilt_angles(in_data_i));
  end

  // receiver stall pattern
  int rx_phase = 0;
  always @(negedge clk_i) begin
    rx_phase = rx_phase + 1;
    if (hold_rx) out_ready_i <= 1'b0;
    else if ((rx_phase / 200) % 2 == 0) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // monitor: one-LSB tolerance on each angle
  always @(posedge clk_i) begin
    ata_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angles_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item pitch=%0d roll=%0d", $time,
                 out_data_o.pitch_angle, out_data_o.roll_angle);
      end else begin
        want = angles_q.pop_front();
        if (int'(out_data_o.pitch_angle) - int'(want.pitch_angle) > 1 ||
            int'(want.pitch_angle) - int'(out_data_o.pitch_angle) > 1) begin
          errors++;
          $display("%0t: pitch expected %0d got %0d", $time,
                   want.pitch_angle, out_data_o.pitch_angle);
        end
        if (int'(out_data_o.roll_angle) - int'(want.roll_angle) > 1 ||
            int'(want.roll_angle) - int'(out_data_o.roll_angle) > 1) begin
          errors++;
          $display("%0t: roll expected %0d got %0d", $time,
                   want.roll_angle, out_data_o.roll_angle);
        end
      end
    end
  end

  task automatic add_sample(int x, int y, int z);
    ata_pkg::in_item_t s;
    s.accel_x = 16'(x); s.accel_y = 16'(y); s.accel_z = 16'(z);
    samples_q.push_back(s);
  endtask

  task automatic wait_drained();
    while (samples_q.size() > 0 || in_valid_i || angles_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    ata_pkg::in_item_t s;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: zeros, extremes, cosine-side zero, x zero with z negative
    add_sample(0, 0, 0);
    add_sample(0, 100, 0);
    add_sample(0, -100, 0);
    add_sample(0, 0, -5);
    add_sample(0, 7, -32768);
    add_sample(0, 0, 32767);
    add_sample(-32768, -32768, -32768);
    add_sample(32767, 32767, 32767);
    add_sample(-32768, 32767, 0);
    add_sample(32767, -32768, 0);
    add_sample(1, 0, -1);
    add_sample(-1, 0, -1);
    add_sample(5, 0, 0);
    add_sample(-5, 0, 0);
    add_sample(-32768, 0, 32767);
    add_sample(32767, 0, -32768);
    add_sample(1, 1, 1);
    add_sample(-1, -1, -1);
    wait_drained();
    // receiver holds off while the sender keeps offering
    hold_rx = 1'b1;
    for (int i = 0; i < 200; i++) begin
      s.accel_x = rnd_axis(); s.accel_y = rnd_axis(); s.accel_z = rnd_axis();
      samples_q.push_back(s);
    end
    for (int c = 0; c < 300; c++) @(posedge clk_i);
    hold_rx = 1'b0;
    wait_drained();
    // random part
    for (int i = 0; i < 1200; i++) begin
      s.accel_x = rnd_axis(); s.accel_y = rnd_axis(); s.accel_z = rnd_axis();
      samples_q.push_back(s);
      if (i % 300 == 299) begin
        while (samples_q.size() > 0) @(posedge clk_i);
        hold_tx = 1'b1;
        wait_drained();
        hold_tx = 1'b0;
      end
    end
    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench: errors");
    $finish;
  end
endmodule
